FILE: rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants of the midi track event parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

   localparam int DEF_MAX_LENGTH_BYTES = 4;
   localparam int DEF_QUEUE_DEPTH      = 4;

   localparam int LEN_W  = 28;
   localparam int TICK_W = 32;

   localparam logic [1:0] KIND_CHANNEL    = 2'd0;
   localparam logic [1:0] KIND_META       = 2'd1;
   localparam logic [1:0] KIND_NO_RUNNING = 2'd2;
   localparam logic [1:0] KIND_TOO_LONG   = 2'd3;

   localparam logic [7:0] MSG_SYSEX     = 8'hf0;
   localparam logic [7:0] MSG_SYSEX_ESC = 8'hf7;
   localparam logic [7:0] MSG_META      = 8'hff;
   localparam logic [3:0] CMD_PROGRAM   = 4'hc;
   localparam logic [3:0] CMD_PRESSURE  = 4'hd;
   localparam logic [3:0] CMD_SYSTEM    = 4'hf;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       track_start;
      logic       is_data;
      logic       is_chan;
      logic       is_sysmeta;
      logic       is_meta;
      logic       one_byte;
   } mtep_item_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TICK_W-1:0] tick;
      logic [3:0]        command;
      logic [3:0]        channel;
      logic [7:0]        first_data;
      logic [7:0]        second_data;
      logic [7:0]        meta_type;
      logic [7:0]        meta_byte;
      logic              byte_valid;
      logic              last_of_event;
   } mtep_result_type;

endpackage

`default_nettype wire

FILE: rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses a track chunk body of a standard midi file one byte at a time.
//
//   port group   direction  handshake          payload
//   req_*        in         req_valid/stall    data_byte, track_start
//   rsp_*        out        rsp_valid/stall    kind, tick, command, channel,
//                                              first_data, second_data,
//                                              meta_type, meta_byte,
//                                              byte_valid, last_of_event
//   apb          in/out     psel/penable       cancel_running_status at 0x0
//
// one byte per cycle sustained while the result channel does not stall; a
// byte passes the input register, a queue entry and the parser result register
// the parser updates its state as it pops each byte, which sets the rate
// reset is synchronous; no clearing pass
// a stalled result holds the parser, the queue then fills and stalls req_
// ----------------------------------------------------------------------------
`default_nettype none

module midi_track_event_parser #(
   parameter int MAX_LENGTH_BYTES = mtep_pkg::DEF_MAX_LENGTH_BYTES,
   parameter int QUEUE_DEPTH      = mtep_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_track_start,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_tick,
   output logic [3:0]       rsp_command,
   output logic [3:0]       rsp_channel,
   output logic [7:0]       rsp_first_data,
   output logic [7:0]       rsp_second_data,
   output logic [7:0]       rsp_meta_type,
   output logic [7:0]       rsp_meta_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last_of_event,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import mtep_pkg::*;

   logic            cancel_ff;
   logic            cancel_in;
   logic            push_valid;
   logic            queue_full;
   mtep_item_type   push_item;
   logic            pop_valid;
   logic            pop;
   mtep_item_type   pop_item;
   mtep_result_type result;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {31'b0, cancel_ff} : 32'b0;

   always_comb begin
      cancel_in = cancel_ff;
      if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         cancel_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cancel_ff <= 1'b1;
      end else begin
         cancel_ff <= cancel_in;
      end
   end

   mtep_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_track_start (req_track_start),
      .push_valid      (push_valid),
      .queue_full      (queue_full),
      .push_item       (push_item)
   );

   mtep_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_item  (pop_item)
   );

   mtep_back #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cancel_running_status (cancel_ff),
      .item_valid            (pop_valid),
      .item                  (pop_item),
      .item_pop              (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .result                (result)
   );

   assign rsp_kind          = result.kind;
   assign rsp_tick          = result.tick;
   assign rsp_command       = result.command;
   assign rsp_channel       = result.channel;
   assign rsp_first_data    = result.first_data;
   assign rsp_second_data   = result.second_data;
   assign rsp_meta_type     = result.meta_type;
   assign rsp_meta_byte     = result.meta_byte;
   assign rsp_byte_valid    = result.byte_valid;
   assign rsp_last_of_event = result.last_of_event;

endmodule

`default_nettype wire

FILE: rtl/mtep_front.sv
// ----------------------------------------------------------------------------
// mtep_front
// Input stage: takes bytes, pre-decodes the status class, hands on to queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_track_start,
   output logic                        push_valid,
   input  wire logic                   queue_full,
   output mtep_pkg::mtep_item_type     push_item
);
   import mtep_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   mtep_item_type item_ff;
   mtep_item_type item_in;
   logic          take;

   assign req_stall  = valid_ff && queue_full;
   assign take       = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in            = take || (valid_ff && queue_full);
      item_in.data_byte   = req_data_byte;
      item_in.track_start = req_track_start;
      item_in.is_data     = !req_data_byte[7];
      item_in.is_chan     = req_data_byte[7] && (req_data_byte[7:4] != CMD_SYSTEM);
      item_in.is_meta     = (req_data_byte == MSG_META);
      item_in.is_sysmeta  = (req_data_byte == MSG_SYSEX) ||
                            (req_data_byte == MSG_SYSEX_ESC) ||
                            (req_data_byte == MSG_META);
      item_in.one_byte    = (req_data_byte[7:4] == CMD_PROGRAM) ||
                            (req_data_byte[7:4] == CMD_PRESSURE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mtep_queue.sv
// ----------------------------------------------------------------------------
// mtep_queue
// Short first-in first-out queue of classified bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_queue #(
   parameter int DEPTH = mtep_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire mtep_pkg::mtep_item_type push_item,
   output logic                        full,
   output logic                        pop_valid,
   input  wire logic                   pop,
   output mtep_pkg::mtep_item_type     pop_item
);
   import mtep_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mtep_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mtep_back.sv
// ----------------------------------------------------------------------------
// mtep_back
// Event parser: delta time, status, data, meta and sysex handling, with the
// result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_back #(
   parameter int MAX_LENGTH_BYTES = mtep_pkg::DEF_MAX_LENGTH_BYTES
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    cancel_running_status,
   input  wire logic                    item_valid,
   input  wire mtep_pkg::mtep_item_type item,
   output logic                         item_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output mtep_pkg::mtep_result_type    result
);
   import mtep_pkg::*;

   localparam int SEEN_W = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;

   localparam logic [2:0] PH_DELTA    = 3'd0;
   localparam logic [2:0] PH_STATUS   = 3'd1;
   localparam logic [2:0] PH_DATA1    = 3'd2;
   localparam logic [2:0] PH_DATA2    = 3'd3;
   localparam logic [2:0] PH_METATYPE = 3'd4;
   localparam logic [2:0] PH_LEN      = 3'd5;
   localparam logic [2:0] PH_PAYLOAD  = 3'd6;

   logic [2:0]        phase_ff,     phase_in;
   logic [TICK_W-1:0] tick_ff,      tick_in;
   logic [LEN_W-1:0]  accum_ff,     accum_in;
   logic [SEEN_W-1:0] seen_ff,      seen_in;
   logic [7:0]        run_status_ff, run_status_in;
   logic              run_valid_ff, run_valid_in;
   logic              run_one_ff,   run_one_in;
   logic [7:0]        cur_status_ff, cur_status_in;
   logic              cur_one_ff,   cur_one_in;
   logic              cur_meta_ff,  cur_meta_in;
   logic [7:0]        held_data_ff, held_data_in;
   logic [7:0]        held_type_ff, held_type_in;
   logic [LEN_W-1:0]  left_ff,      left_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mtep_result_type   result_ff,    result_in;

   logic [2:0]        ph;
   logic [TICK_W-1:0] tk;
   logic [LEN_W-1:0]  acc;
   logic [SEEN_W-1:0] seen;
   logic              rv;
   logic [LEN_W-1:0]  vlq_acc;
   logic              vlq_long;
   logic [LEN_W-1:0]  left_dec;
   logic [7:0]        b;

   assign item_pop  = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   always_comb begin
      b        = item.data_byte;
      ph       = item.track_start ? PH_DELTA : phase_ff;
      tk       = item.track_start ? '0 : tick_ff;
      acc      = item.track_start ? '0 : accum_ff;
      seen     = item.track_start ? '0 : seen_ff;
      rv       = item.track_start ? 1'b0 : run_valid_ff;
      vlq_acc  = {acc[LEN_W-8:0], b[6:0]};
      vlq_long = b[7] && (seen == SEEN_W'(MAX_LENGTH_BYTES - 1));
      left_dec = left_ff - LEN_W'(1);

      phase_in      = ph;
      tick_in       = tk;
      accum_in      = acc;
      seen_in       = seen;
      run_status_in = run_status_ff;
      run_valid_in  = rv;
      run_one_in    = run_one_ff;
      cur_status_in = cur_status_ff;
      cur_one_in    = cur_one_ff;
      cur_meta_in   = cur_meta_ff;
      held_data_in  = held_data_ff;
      held_type_in  = held_type_ff;
      left_in       = left_ff;

      rsp_valid_in  = 1'b0;
      result_in     = '0;
      result_in.tick = tk;

      case (ph)
         PH_DELTA: begin
            accum_in = vlq_acc;
            if (!b[7]) begin
               tick_in  = tk + TICK_W'(vlq_acc);
               phase_in = PH_STATUS;
            end else if (vlq_long) begin
               rsp_valid_in   = 1'b1;
               result_in.kind = KIND_TOO_LONG;
               accum_in       = '0;
               seen_in        = '0;
            end else begin
               seen_in = seen + SEEN_W'(1);
            end
         end
         PH_STATUS: begin
            if (item.is_data) begin
               if (!rv) begin
                  rsp_valid_in   = 1'b1;
                  result_in.kind = KIND_NO_RUNNING;
                  phase_in       = PH_DELTA;
                  accum_in       = '0;
                  seen_in        = '0;
               end else begin
                  cur_status_in = run_status_ff;
                  cur_one_in    = run_one_ff;
                  cur_meta_in   = 1'b0;
                  if (run_one_ff) begin
                     rsp_valid_in         = 1'b1;
                     result_in.kind       = KIND_CHANNEL;
                     result_in.command    = run_status_ff[7:4];
                     result_in.channel    = run_status_ff[3:0];
                     result_in.first_data = b;
                     phase_in             = PH_DELTA;
                     accum_in             = '0;
                     seen_in              = '0;
                  end else begin
                     held_data_in = b;
                     phase_in     = PH_DATA2;
                  end
               end
            end else if (item.is_chan) begin
               cur_status_in = b;
               cur_one_in    = item.one_byte;
               cur_meta_in   = 1'b0;
               run_status_in = b;
               run_one_in    = item.one_byte;
               run_valid_in  = 1'b1;
               phase_in      = PH_DATA1;
            end else if (item.is_sysmeta) begin
               if (cancel_running_status) begin
                  run_valid_in = 1'b0;
               end
               cur_status_in = b;
               cur_one_in    = 1'b0;
               cur_meta_in   = item.is_meta;
               phase_in      = item.is_meta ? PH_METATYPE : PH_LEN;
               accum_in      = '0;
               seen_in       = '0;
            end else begin
               phase_in = PH_DELTA;
               accum_in = '0;
               seen_in  = '0;
            end
         end
         PH_DATA1: begin
            if (cur_one_ff) begin
               rsp_valid_in         = 1'b1;
               result_in.kind       = KIND_CHANNEL;
               result_in.command    = cur_status_ff[7:4];
               result_in.channel    = cur_status_ff[3:0];
               result_in.first_data = b;
               phase_in             = PH_DELTA;
               accum_in             = '0;
               seen_in              = '0;
            end else begin
               held_data_in = b;
               phase_in     = PH_DATA2;
            end
         end
         PH_DATA2: begin
            rsp_valid_in          = 1'b1;
            result_in.kind        = KIND_CHANNEL;
            result_in.command     = cur_status_ff[7:4];
            result_in.channel     = cur_status_ff[3:0];
            result_in.first_data  = held_data_ff;
            result_in.second_data = b;
            phase_in              = PH_DELTA;
            accum_in              = '0;
            seen_in               = '0;
         end
         PH_METATYPE: begin
            held_type_in = b;
            phase_in     = PH_LEN;
            accum_in     = '0;
            seen_in      = '0;
         end
         PH_LEN: begin
            accum_in = vlq_acc;
            if (vlq_long) begin
               rsp_valid_in   = 1'b1;
               result_in.kind = KIND_TOO_LONG;
               phase_in       = PH_DELTA;
               accum_in       = '0;
               seen_in        = '0;
            end else if (b[7]) begin
               seen_in = seen + SEEN_W'(1);
            end else begin
               left_in = vlq_acc;
               if (vlq_acc != '0) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_DELTA;
                  accum_in = '0;
                  seen_in  = '0;
                  if (cur_meta_ff) begin
                     rsp_valid_in            = 1'b1;
                     result_in.kind          = KIND_META;
                     result_in.meta_type     = held_type_ff;
                     result_in.last_of_event = 1'b1;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_DELTA;
               accum_in = '0;
               seen_in  = '0;
            end
            if (cur_meta_ff) begin
               rsp_valid_in            = 1'b1;
               result_in.kind          = KIND_META;
               result_in.meta_type     = held_type_ff;
               result_in.meta_byte     = b;
               result_in.byte_valid    = 1'b1;
               result_in.last_of_event = (left_dec == '0);
            end
         end
         default: begin
            phase_in = PH_DELTA;
            accum_in = '0;
            seen_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DELTA;
         tick_ff      <= '0;
         accum_ff     <= '0;
         seen_ff      <= '0;
         run_valid_ff <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            accum_ff     <= accum_in;
            seen_ff      <= seen_in;
            run_valid_ff <= run_valid_in;
            left_ff      <= left_in;
            rsp_valid_ff <= rsp_valid_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (item_pop) begin
         run_status_ff <= run_status_in;
         run_one_ff    <= run_one_in;
         cur_status_ff <= cur_status_in;
         cur_one_ff    <= cur_one_in;
         cur_meta_ff   <= cur_meta_in;
         held_data_ff  <= held_data_in;
         held_type_ff  <= held_type_in;
         if (rsp_valid_in) begin
            result_ff <= result_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: sim/mtep_checker.sv
// ----------------------------------------------------------------------------
// mtep_checker
// Watches the byte and result channels of the midi track event parser and
// the register port, keeps its own copy of the parser state, queues the
// results each accepted byte should give and compares every accepted result
// field by field against the oldest one. Counts failures for the top level.
// ----------------------------------------------------------------------------
module mtep_checker #(
   parameter logic [2:0] CANCEL_ADDR = 3'd0
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_track_start,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [31:0] rsp_tick,
   input  logic [3:0]  rsp_command,
   input  logic [3:0]  rsp_channel,
   input  logic [7:0]  rsp_first_data,
   input  logic [7:0]  rsp_second_data,
   input  logic [7:0]  rsp_meta_type,
   input  logic [7:0]  rsp_meta_byte,
   input  logic        rsp_byte_valid,
   input  logic        rsp_last_of_event,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,

   output int          mismatch_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import mtep_pkg::*;

   typedef enum logic [2:0] {
      P_DELTA,
      P_STATUS,
      P_DATA1,
      P_DATA2,
      P_META_TYPE,
      P_LENGTH,
      P_PAYLOAD
   } parse_phase_type;

   localparam int MAX_VLQ_BYTES = DEF_MAX_LENGTH_BYTES;

   parse_phase_type phase;
   logic [31:0]     tick_total;
   logic [27:0]     len_accum;
   logic [2:0]      len_seen;
   logic [7:0]      run_status;
   logic            run_valid;
   logic [7:0]      cur_status;
   logic [7:0]      held_data;
   logic [7:0]      held_type;
   logic [27:0]     payload_left;
   logic            cancel_rs;

   mtep_result_type expected_events[$];
   int              fail_count = 0;
   int              waiting = 0;

   assign mismatch_count = fail_count;
   assign pending        = waiting;

   function automatic mtep_result_type blank_result();
      mtep_result_type r;
      r      = '0;
      r.tick = tick_total;
      return r;
   endfunction

   function automatic bit single_data(input logic [7:0] s);
      return s[7:4] == CMD_PROGRAM || s[7:4] == CMD_PRESSURE;
   endfunction

   task automatic restart_vlq(input parse_phase_type nxt);
      len_accum = '0;
      len_seen  = '0;
      phase     = nxt;
   endtask

   // 0 more bytes needed, 1 value complete, 2 value too long
   function automatic int take_vlq(input logic [7:0] b);
      len_accum = {len_accum[20:0], b[6:0]};
      if (!b[7]) return 1;
      if (int'(len_seen) + 1 >= MAX_VLQ_BYTES) return 2;
      len_seen = len_seen + 3'd1;
      return 0;
   endfunction

   task automatic push_kind(input logic [1:0] k);
      mtep_result_type r;
      r      = blank_result();
      r.kind = k;
      expected_events.insert(expected_events.size(), r);
   endtask

   task automatic push_channel(input logic [7:0] d1, input logic [7:0] d2);
      mtep_result_type r;
      r             = blank_result();
      r.kind        = KIND_CHANNEL;
      r.command     = cur_status[7:4];
      r.channel     = cur_status[3:0];
      r.first_data  = d1;
      r.second_data = d2;
      expected_events.insert(expected_events.size(), r);
   endtask

   task automatic push_meta(input logic [7:0] b, input logic bv, input logic last);
      mtep_result_type r;
      r               = blank_result();
      r.kind          = KIND_META;
      r.meta_type     = held_type;
      r.meta_byte     = b;
      r.byte_valid    = bv;
      r.last_of_event = last;
      expected_events.insert(expected_events.size(), r);
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic ts);
      int v;
      if (ts) begin
         tick_total = '0;
         run_status = '0;
         run_valid  = 1'b0;
         restart_vlq(P_DELTA);
      end
      case (phase)
         P_DELTA: begin
            v = take_vlq(b);
            if (v == 1) begin
               tick_total = tick_total + 32'(len_accum);
               phase      = P_STATUS;
            end else if (v == 2) begin
               push_kind(KIND_TOO_LONG);
               restart_vlq(P_DELTA);
            end
         end
         P_STATUS: begin
            if (!b[7]) begin
               if (!run_valid) begin
                  push_kind(KIND_NO_RUNNING);
                  restart_vlq(P_DELTA);
               end else begin
                  cur_status = run_status;
                  if (single_data(cur_status)) begin
                     restart_vlq(P_DELTA);
                     push_channel(b, 8'h00);
                  end else begin
                     held_data = b;
                     phase     = P_DATA2;
                  end
               end
            end else if (b[7:4] != CMD_SYSTEM) begin
               cur_status = b;
               run_status = b;
               run_valid  = 1'b1;
               phase      = P_DATA1;
            end else if (b == MSG_SYSEX || b == MSG_SYSEX_ESC || b == MSG_META) begin
               if (cancel_rs) run_valid = 1'b0;
               cur_status = b;
               if (b == MSG_META) phase = P_META_TYPE;
               else restart_vlq(P_LENGTH);
            end else begin
               restart_vlq(P_DELTA);
            end
         end
         P_DATA1: begin
            if (single_data(cur_status)) begin
               restart_vlq(P_DELTA);
               push_channel(b, 8'h00);
            end else begin
               held_data = b;
               phase     = P_DATA2;
            end
         end
         P_DATA2: begin
            restart_vlq(P_DELTA);
            push_channel(held_data, b);
         end
         P_META_TYPE: begin
            held_type = b;
            restart_vlq(P_LENGTH);
         end
         P_LENGTH: begin
            v = take_vlq(b);
            if (v == 2) begin
               push_kind(KIND_TOO_LONG);
               restart_vlq(P_DELTA);
            end else if (v == 1) begin
               payload_left = len_accum;
               if (payload_left != 0) begin
                  phase = P_PAYLOAD;
               end else begin
                  restart_vlq(P_DELTA);
                  if (cur_status == MSG_META) push_meta(8'h00, 1'b0, 1'b1);
               end
            end
         end
         P_PAYLOAD: begin
            payload_left = payload_left - 28'd1;
            if (payload_left == 0) restart_vlq(P_DELTA);
            if (cur_status == MSG_META) push_meta(b, 1'b1, payload_left == 0);
         end
         default: begin
            restart_vlq(P_DELTA);
         end
      endcase
   endtask

   task automatic check_result();
      mtep_result_type got;
      mtep_result_type want;
      got.kind          = rsp_kind;
      got.tick          = rsp_tick;
      got.command       = rsp_command;
      got.channel       = rsp_channel;
      got.first_data    = rsp_first_data;
      got.second_data   = rsp_second_data;
      got.meta_type     = rsp_meta_type;
      got.meta_byte     = rsp_meta_byte;
      got.byte_valid    = rsp_byte_valid;
      got.last_of_event = rsp_last_of_event;
      if (expected_events.size() == 0) begin
         if (fail_count < 10)
            $display("%0t: result with none expected: kind=%0d tick=%h", $realtime,
                     got.kind, got.tick);
         fail_count++;
         return;
      end
      want = expected_events.pop_front();
      if (got.kind !== want.kind || got.tick !== want.tick ||
          got.command !== want.command || got.channel !== want.channel ||
          got.first_data !== want.first_data || got.second_data !== want.second_data ||
          got.meta_type !== want.meta_type || got.meta_byte !== want.meta_byte ||
          got.byte_valid !== want.byte_valid || got.last_of_event !== want.last_of_event) begin
         if (fail_count < 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  exp kind=%0d tick=%h cmd=%h ch=%h d1=%h d2=%h type=%h byte=%h bv=%b last=%b",
                     want.kind, want.tick, want.command, want.channel, want.first_data,
                     want.second_data, want.meta_type, want.meta_byte, want.byte_valid,
                     want.last_of_event);
            $display("  act kind=%0d tick=%h cmd=%h ch=%h d1=%h d2=%h type=%h byte=%h bv=%b last=%b",
                     got.kind, got.tick, got.command, got.channel, got.first_data,
                     got.second_data, got.meta_type, got.meta_byte, got.byte_valid,
                     got.last_of_event);
         end
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cancel_rs    = 1'b1;
         tick_total   = '0;
         run_status   = '0;
         run_valid    = 1'b0;
         cur_status   = '0;
         held_data    = '0;
         held_type    = '0;
         payload_left = '0;
         restart_vlq(P_DELTA);
         expected_events.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == CANCEL_ADDR)
            cancel_rs = pwdata[0];
         if (req_valid && !req_stall) parse_byte(req_data_byte, req_track_start);
         if (rsp_valid && !rsp_stall) check_result();
      end
      waiting <= expected_events.size();
   end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the midi track event parser. Drives track bytes, mostly
// well-formed events (delta times, channel messages with and without running
// status, meta and sysex events, undefined statuses) mixed with noise and
// overlong lengths, under three idling patterns and both settings of the
// running status cancel register. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mtep_pkg::*;

   localparam logic [2:0] CANCEL_ADDR = 3'd0;
   localparam int         PHASE_ITEMS = 430;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte   = 8'h00;
   logic        req_track_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_tick;
   logic [3:0]  rsp_command;
   logic [3:0]  rsp_channel;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   logic [7:0]  rsp_meta_type;
   logic [7:0]  rsp_meta_byte;
   logic        rsp_byte_valid;
   logic        rsp_last_of_event;
   logic        psel            = 1'b0;
   logic        penable         = 1'b0;
   logic        pwrite          = 1'b0;
   logic [2:0]  paddr           = 3'd0;
   logic [31:0] pwdata          = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int          send_idle_pct    = 0;
   int          stall_pct        = 0;
   int          bytes_sent       = 0;
   logic [7:0]  last_chan_status = 8'h90;
   int          mismatch_count;
   int          pending;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   midi_track_event_parser uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_track_start   (req_track_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_tick          (rsp_tick),
      .rsp_command       (rsp_command),
      .rsp_channel       (rsp_channel),
      .rsp_first_data    (rsp_first_data),
      .rsp_second_data   (rsp_second_data),
      .rsp_meta_type     (rsp_meta_type),
      .rsp_meta_byte     (rsp_meta_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_event (rsp_last_of_event),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   mtep_checker #(.CANCEL_ADDR(CANCEL_ADDR)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_track_start   (req_track_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_tick          (rsp_tick),
      .rsp_command       (rsp_command),
      .rsp_channel       (rsp_channel),
      .rsp_first_data    (rsp_first_data),
      .rsp_second_data   (rsp_second_data),
      .rsp_meta_type     (rsp_meta_type),
      .rsp_meta_byte     (rsp_meta_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_event (rsp_last_of_event),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .pready            (pready),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .mismatch_count    (mismatch_count),
      .pending           (pending)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // called just after a falling edge, returns just after one
   task automatic send_byte(input logic [7:0] b, input logic ts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_track_start <= ts;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // most significant group first, padded with empty groups up to width
   task automatic send_vlq(input logic [27:0] value, input int width, input logic ts);
      int         n;
      int         i;
      logic [7:0] b;
      n = 1;
      while (n < 4 && (value >> (7 * n)) != 0) n++;
      if (width > n) n = width;
      for (i = n - 1; i >= 0; i--) begin
         b = {i != 0, 7'(value >> (7 * i))};
         send_byte(b, (i == n - 1) ? ts : 1'b0);
      end
   endtask

   task automatic send_overlong(input logic ts);
      int i;
      for (i = 0; i < 4; i++) send_byte({1'b1, 7'($urandom_range(127))}, (i == 0) ? ts : 1'b0);
   endtask

   function automatic logic [27:0] pick_delta();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 28'd0;
      if (r < 75) return 28'($urandom_range(1, 127));
      if (r < 93) return 28'($urandom_range(128, 16383));
      if (r < 98) return 28'($urandom_range(16384, 28'h0ff_fffe));
      return 28'h0ff_ffff;
   endfunction

   function automatic int pick_width();
      return ($urandom_range(9) == 0) ? $urandom_range(2, 4) : 1;
   endfunction

   function automatic logic [7:0] pick_data();
      return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
   endfunction

   task automatic send_chan_data(input logic [7:0] s, input logic [7:0] first);
      send_byte(first, 1'b0);
      if (s[7:4] != CMD_PROGRAM && s[7:4] != CMD_PRESSURE) send_byte(pick_data(), 1'b0);
   endtask

   task automatic send_length_and_payload();
      int r;
      int n;
      int i;
      if ($urandom_range(49) == 0) begin
         send_overlong(1'b0);
         return;
      end
      r = $urandom_range(9);
      if (r < 6) n = $urandom_range(4);
      else if (r < 9) n = $urandom_range(5, 12);
      else n = $urandom_range(13, 40);
      send_vlq(28'(n), pick_width(), 1'b0);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic send_event();
      int         pick;
      int         n;
      int         i;
      logic [7:0] s;
      logic       ts;
      ts   = ($urandom_range(99) < 3);
      pick = $urandom_range(99);
      if (pick < 8) begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
         return;
      end
      if ($urandom_range(99) < 3) begin
         send_overlong(ts);
         return;
      end
      send_vlq(pick_delta(), pick_width(), ts);
      if (pick < 43) begin
         s = 8'($urandom_range(8'h80, 8'hef));
         last_chan_status = s;
         send_byte(s, 1'b0);
         send_chan_data(s, pick_data());
      end else if (pick < 63) begin
         send_chan_data(last_chan_status, 8'($urandom_range(127)));
      end else if (pick < 83) begin
         send_byte(MSG_META, 1'b0);
         send_byte(8'($urandom_range(255)), 1'b0);
         send_length_and_payload();
      end else if (pick < 91) begin
         send_byte($urandom_range(1) ? MSG_SYSEX : MSG_SYSEX_ESC, 1'b0);
         send_length_and_payload();
      end else if (pick < 95) begin
         s = 8'($urandom_range(8'hf1, 8'hfe));
         if (s == MSG_SYSEX_ESC) s = 8'hf1;
         send_byte(s, 1'b0);
      end else begin
         send_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_directed();
      // data byte with no running status
      send_byte(8'h00, 1'b1);
      send_byte(8'h45, 1'b0);
      // delta too long
      send_overlong(1'b0);
      // program change then running status reuse
      send_byte(8'h81, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hc5, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h12, 1'b0);
      // status-like bytes in data positions
      send_byte(8'h00, 1'b0);
      send_byte(8'h9f, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hff, 1'b0);
      // undefined status
      send_byte(8'h00, 1'b0);
      send_byte(8'hf3, 1'b0);
      // empty meta event
      send_byte(8'h00, 1'b0);
      send_byte(MSG_META, 1'b0);
      send_byte(8'h2f, 1'b0);
      send_byte(8'h00, 1'b0);
      // sysex with one skipped byte
      send_byte(8'h7f, 1'b0);
      send_byte(MSG_SYSEX, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(MSG_SYSEX_ESC, 1'b0);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_write(CANCEL_ADDR, 32'd0);
      send_idle_pct = 12;
      stall_pct     = 68;
      send_directed();
      while (bytes_sent < PHASE_ITEMS) send_event();

      drain();
      csr_write(CANCEL_ADDR, 32'd1);
      send_idle_pct = 68;
      stall_pct     = 12;
      while (bytes_sent < 2 * PHASE_ITEMS) send_event();

      drain();
      csr_write(CANCEL_ADDR, 32'd0);
      send_idle_pct = 0;
      stall_pct     = 0;
      while (bytes_sent < 3 * PHASE_ITEMS) send_event();

      drain();
      if (mismatch_count == 0 && pending == 0) begin
         $display("midi_track_event_parser regression: pass");
      end else begin
         $display("midi_track_event_parser regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("midi_track_event_parser regression: fail");
      $finish;
   end

endmodule
